FILE: src/aus_pkg.sv
package aus_pkg;

  localparam int DEPTH = 64;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    logic [6:0]        col;
    logic [6:0]        row;
    logic signed [7:0] value;
    logic signed [7:0] mark;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  localparam logic signed [7:0] MARK_ANCHOR = 8'sd1;
  localparam logic signed [7:0] MARK_NONE   = -8'sd1;
  localparam logic signed [7:0] MARK_CLEAR  = 8'sd0;

  typedef enum logic [2:0] {
    OP_PUSH   = 3'd0,
    OP_POP    = 3'd1,
    OP_PEEK   = 3'd2,
    OP_ANCHOR = 3'd3,
    OP_APPEND = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } fsm_t;

endpackage

FILE: src/aus_ram.sv
module aus_ram #(
  parameter int DEPTH  = 64,
  parameter int ADDR_W = 6,
  parameter int DATA_W = 30
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/aus_ctrl.sv
module aus_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [2:0]              operation,
  input  logic [6:0]              in_col,
  input  logic [6:0]              in_row,
  input  logic signed [7:0]       in_value,
  input  logic signed [7:0]       in_mark,
  output logic                    ram_re,
  output aus_pkg::ptr_t           ram_raddr,
  input  aus_pkg::entry_t         ram_rdata,
  output logic                    ram_we,
  output aus_pkg::ptr_t           ram_waddr,
  output aus_pkg::entry_t         ram_wdata,
  output logic                    done,
  output logic [1:0]              status,
  output logic [6:0]              out_col,
  output logic [6:0]              out_row,
  output logic signed [7:0]       out_value,
  output logic signed [7:0]       out_mark,
  output logic                    anchor_present,
  output logic                    is_empty,
  output logic [aus_pkg::CNT_W-1:0] fill_count
);

  aus_pkg::fsm_t state, state_next;
  aus_pkg::ptr_t top, top_next;
  aus_pkg::cnt_t count, count_next;
  aus_pkg::cnt_t anchors, anchors_next;

  // captured item
  logic [2:0]        op;
  logic [6:0]        col;
  logic [6:0]        row;
  logic signed [7:0] value;
  logic signed [7:0] mark;

  aus_pkg::ptr_t      top_idx;
  aus_pkg::ptr_t      top_inc;
  aus_pkg::ptr_t      app_idx;
  logic [aus_pkg::PTR_W:0] app_sum;

  logic [1:0]        r_status;
  logic [6:0]        r_col;
  logic [6:0]        r_row;
  logic signed [7:0] r_value;
  logic signed [7:0] r_mark;
  logic              accept;

  assign busy   = (state == aus_pkg::S_EXEC);
  assign accept = start && !busy;

  assign top_idx = (top == '0) ? aus_pkg::PTR_W'(aus_pkg::DEPTH - 1) : top - 1'b1;
  assign top_inc = (top == aus_pkg::PTR_W'(aus_pkg::DEPTH - 1)) ? '0 : top + 1'b1;

  // slot below the bottom entry: top - count - 1, wrapped
  assign app_sum = {1'b0, top} + (aus_pkg::PTR_W + 1)'(aus_pkg::DEPTH)
                 - (aus_pkg::PTR_W + 1)'(count) - 1'b1;
  assign app_idx = (app_sum >= (aus_pkg::PTR_W + 1)'(aus_pkg::DEPTH))
                 ? aus_pkg::PTR_W'(app_sum - (aus_pkg::PTR_W + 1)'(aus_pkg::DEPTH))
                 : aus_pkg::PTR_W'(app_sum);

  // top entry is fetched on the transfer edge, ready during S_EXEC
  assign ram_re    = accept;
  assign ram_raddr = top_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= aus_pkg::S_IDLE;
      top     <= '0;
      count   <= '0;
      anchors <= '0;
      done    <= 1'b0;
    end else begin
      state   <= state_next;
      top     <= top_next;
      count   <= count_next;
      anchors <= anchors_next;
      done    <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op    <= operation;
      col   <= in_col;
      row   <= in_row;
      value <= in_value;
      mark  <= in_mark;
    end
    if (busy) begin
      status         <= r_status;
      out_col        <= r_col;
      out_row        <= r_row;
      out_value      <= r_value;
      out_mark       <= r_mark;
      anchor_present <= (anchors_next != '0);
      is_empty       <= (count_next == '0);
      fill_count     <= count_next;
    end
  end

  always_comb begin
    state_next   = state;
    top_next     = top;
    count_next   = count;
    anchors_next = anchors;
    ram_we       = 1'b0;
    ram_waddr    = top_idx;
    ram_wdata    = ram_rdata;
    r_status     = aus_pkg::ST_OK;
    r_col        = '0;
    r_row        = '0;
    r_value      = '0;
    r_mark       = aus_pkg::MARK_CLEAR;

    unique case (state)
      aus_pkg::S_IDLE: begin
        if (start) begin
          state_next = aus_pkg::S_EXEC;
        end
      end
      aus_pkg::S_EXEC: begin
        state_next = aus_pkg::S_IDLE;
        priority if ((op == aus_pkg::OP_POP || op == aus_pkg::OP_PEEK
                      || op == aus_pkg::OP_ANCHOR) && count == '0) begin
          r_status = aus_pkg::ST_EMPTY;
          r_mark   = aus_pkg::MARK_NONE;
        end else if ((op == aus_pkg::OP_PUSH || op == aus_pkg::OP_APPEND)
                     && count == aus_pkg::CNT_W'(aus_pkg::DEPTH)) begin
          r_status = aus_pkg::ST_FULL;
        end else begin
          unique case (op)
            aus_pkg::OP_PUSH: begin
              ram_we          = 1'b1;
              ram_waddr       = top;
              ram_wdata.col   = col;
              ram_wdata.row   = row;
              ram_wdata.value = value;
              ram_wdata.mark  = aus_pkg::MARK_CLEAR;
              top_next        = top_inc;
              count_next      = count + 1'b1;
            end
            aus_pkg::OP_POP: begin
              r_col   = ram_rdata.col;
              r_row   = ram_rdata.row;
              r_value = ram_rdata.value;
              r_mark  = ram_rdata.mark;
              if (ram_rdata.mark == aus_pkg::MARK_ANCHOR && anchors != '0) begin
                anchors_next = anchors - 1'b1;
              end
              top_next   = top_idx;
              count_next = count - 1'b1;
            end
            aus_pkg::OP_PEEK: begin
              r_mark = ram_rdata.mark;
              if (ram_rdata.mark == aus_pkg::MARK_ANCHOR && anchors != '0) begin
                anchors_next = anchors - 1'b1;
              end
              ram_we         = 1'b1;
              ram_wdata.mark = aus_pkg::MARK_CLEAR;
            end
            aus_pkg::OP_ANCHOR: begin
              if (ram_rdata.mark != aus_pkg::MARK_ANCHOR) begin
                anchors_next = anchors + 1'b1;
              end
              ram_we         = 1'b1;
              ram_wdata.mark = aus_pkg::MARK_ANCHOR;
            end
            aus_pkg::OP_APPEND: begin
              ram_we          = 1'b1;
              ram_waddr       = app_idx;
              ram_wdata.col   = col;
              ram_wdata.row   = row;
              ram_wdata.value = value;
              ram_wdata.mark  = mark;
              if (mark == aus_pkg::MARK_ANCHOR) begin
                anchors_next = anchors + 1'b1;
              end
              count_next = count + 1'b1;
            end
            default: begin
              // unused opcodes: no state change, ok status
            end
          endcase
        end
      end
      default: begin
        state_next = aus_pkg::S_IDLE;
      end
    endcase
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= aus_pkg::CNT_W'(aus_pkg::DEPTH))
    else $error("entry count beyond depth");

  a_anchor_bound: assert property (@(posedge clk) disable iff (rst)
    anchors <= count)
    else $error("more anchors than entries");

  a_write_in_exec: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> state == aus_pkg::S_EXEC)
    else $error("memory write outside execute step");

  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    state == aus_pkg::S_EXEC |=> done && state == aus_pkg::S_IDLE)
    else $error("result strobe missing after execute step");

  a_top_moves_on_count: assert property (@(posedge clk) disable iff (rst)
    $past(state) == aus_pkg::S_IDLE && state == aus_pkg::S_IDLE |-> $stable(count)
    && $stable(top) && $stable(anchors))
    else $error("state changed without a transfer");

endmodule

FILE: src/anchored_undo_stack_top.sv
// channel  | transfer when      | ports
// ---------+--------------------+---------------------------------------------
// command  | start && !busy     | operation, in_col, in_row, in_value, in_mark
// result   | done (one cycle)   | status, out_col, out_row, out_value,
//          |                    | out_mark, anchor_present, is_empty, fill_count
//
// Each command reads the top entry from the entry memory on the transfer
// edge, then modifies it and writes it back during the execute cycle.
// done rises the cycle after that; a new command may transfer in that same cycle.
// busy is high only during the execute cycle.
// rst clears pointers and counts; memory contents are not cleared.
// The result is strobed for one cycle and cannot be held off.
module anchored_undo_stack_top (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [2:0]                operation,
  input  logic [6:0]                in_col,
  input  logic [6:0]                in_row,
  input  logic signed [7:0]         in_value,
  input  logic signed [7:0]         in_mark,
  output logic                      done,
  output logic [1:0]                status,
  output logic [6:0]                out_col,
  output logic [6:0]                out_row,
  output logic signed [7:0]         out_value,
  output logic signed [7:0]         out_mark,
  output logic                      anchor_present,
  output logic                      is_empty,
  output logic [aus_pkg::CNT_W-1:0] fill_count
);

  logic            ram_re;
  logic            ram_we;
  aus_pkg::ptr_t   ram_raddr;
  aus_pkg::ptr_t   ram_waddr;
  aus_pkg::entry_t ram_rdata;
  aus_pkg::entry_t ram_wdata;

  aus_ram #(
    .DEPTH  (aus_pkg::DEPTH),
    .ADDR_W (aus_pkg::PTR_W),
    .DATA_W (aus_pkg::ENTRY_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  aus_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .operation      (operation),
    .in_col         (in_col),
    .in_row         (in_row),
    .in_value       (in_value),
    .in_mark        (in_mark),
    .ram_re         (ram_re),
    .ram_raddr      (ram_raddr),
    .ram_rdata      (ram_rdata),
    .ram_we         (ram_we),
    .ram_waddr      (ram_waddr),
    .ram_wdata      (ram_wdata),
    .done           (done),
    .status         (status),
    .out_col        (out_col),
    .out_row        (out_row),
    .out_value      (out_value),
    .out_mark       (out_mark),
    .anchor_present (anchor_present),
    .is_empty       (is_empty),
    .fill_count     (fill_count)
  );

endmodule

FILE: tb/tb_anchored_undo_stack_top.sv
`timescale 1ns / 1ps

module tb_anchored_undo_stack_top;
  import aus_pkg::*;

  localparam int RANDOM_ITEMS = 1550;
  localparam int QUIET_TAIL   = 120;
  localparam int CYCLE_LIMIT  = 200000;

  typedef struct {
    logic [2:0]        operation;
    logic [6:0]        col;
    logic [6:0]        row;
    logic signed [7:0] value;
    logic signed [7:0] mark;
  } stack_cmd_t;

  typedef struct {
    status_t           status;
    logic [6:0]        col;
    logic [6:0]        row;
    logic signed [7:0] value;
    logic signed [7:0] mark;
    logic              anchor;
    logic              empty;
    cnt_t              fill;
  } stack_result_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic [2:0]          operation = OP_PUSH;
  logic [6:0]          in_col = '0;
  logic [6:0]          in_row = '0;
  logic signed [7:0]   in_value = '0;
  logic signed [7:0]   in_mark = '0;
  logic                busy;
  logic                done;
  logic [1:0]          status;
  logic [6:0]          out_col;
  logic [6:0]          out_row;
  logic signed [7:0]   out_value;
  logic signed [7:0]   out_mark;
  logic                anchor_present;
  logic                is_empty;
  logic [CNT_W-1:0]    fill_count;

  stack_cmd_t          cmd_queue[$];
  stack_result_t       pending_results[$];

  // shadow copy of the stack
  entry_t              stack_mem[DEPTH];
  ptr_t                top_ptr = '0;
  cnt_t                depth_now = '0;
  int unsigned         anchor_total = 0;

  int                  mismatch_count = 0;
  int                  idle_left = 0;
  int                  cycle_count = 0;

  anchored_undo_stack_top u_top (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .operation      (operation),
    .in_col         (in_col),
    .in_row         (in_row),
    .in_value       (in_value),
    .in_mark        (in_mark),
    .done           (done),
    .status         (status),
    .out_col        (out_col),
    .out_row        (out_row),
    .out_value      (out_value),
    .out_mark       (out_mark),
    .anchor_present (anchor_present),
    .is_empty       (is_empty),
    .fill_count     (fill_count)
  );

  always #10 clk = ~clk;

  function automatic stack_result_t stack_step(stack_cmd_t c);
    stack_result_t r;
    ptr_t          top_slot;
    ptr_t          tail_slot;
    r.status = ST_OK;
    r.col    = '0;
    r.row    = '0;
    r.value  = '0;
    r.mark   = MARK_CLEAR;
    top_slot = top_ptr - ptr_t'(1);
    if ((c.operation == OP_POP || c.operation == OP_PEEK || c.operation == OP_ANCHOR)
        && depth_now == 0) begin
      r.status = ST_EMPTY;
      r.mark   = MARK_NONE;
    end else if ((c.operation == OP_PUSH || c.operation == OP_APPEND) && depth_now >= DEPTH) begin
      r.status = ST_FULL;
    end else begin
      case (c.operation)
        OP_PUSH: begin
          stack_mem[top_ptr] = '{c.col, c.row, c.value, MARK_CLEAR};
          top_ptr   = top_ptr + ptr_t'(1);
          depth_now = depth_now + cnt_t'(1);
        end
        OP_POP: begin
          r.col   = stack_mem[top_slot].col;
          r.row   = stack_mem[top_slot].row;
          r.value = stack_mem[top_slot].value;
          r.mark  = stack_mem[top_slot].mark;
          if (stack_mem[top_slot].mark == MARK_ANCHOR && anchor_total > 0) anchor_total--;
          top_ptr   = top_slot;
          depth_now = depth_now - cnt_t'(1);
        end
        OP_PEEK: begin
          r.mark = stack_mem[top_slot].mark;
          if (stack_mem[top_slot].mark == MARK_ANCHOR && anchor_total > 0) anchor_total--;
          stack_mem[top_slot].mark = MARK_CLEAR;
        end
        OP_ANCHOR: begin
          if (stack_mem[top_slot].mark != MARK_ANCHOR) anchor_total++;
          stack_mem[top_slot].mark = MARK_ANCHOR;
        end
        OP_APPEND: begin
          // bottom slot sits one below the oldest live entry in the ring
          tail_slot = top_ptr - ptr_t'(depth_now) - ptr_t'(1);
          stack_mem[tail_slot] = '{c.col, c.row, c.value, c.mark};
          if (c.mark == MARK_ANCHOR) anchor_total++;
          depth_now = depth_now + cnt_t'(1);
        end
        default: ;
      endcase
    end
    r.anchor = (anchor_total != 0);
    r.empty  = (depth_now == 0);
    r.fill   = depth_now;
    return r;
  endfunction

  function automatic stack_cmd_t make_cmd(logic [2:0] op);
    stack_cmd_t c;
    c.operation = op;
    c.col       = 7'($urandom);
    c.row       = 7'($urandom);
    c.value     = 8'($urandom);
    c.mark      = 8'($urandom);
    if (op == OP_APPEND && $urandom_range(0, 2) == 0) c.mark = MARK_ANCHOR;
    return c;
  endfunction

  // mode 0 grows the stack toward full, 1 drains it, 2 is a mix that grows it more slowly
  function automatic logic [2:0] pick_op(int mode);
    int unsigned cut[5];
    int unsigned r;
    case (mode)
      0:       cut = '{45, 85, 92, 96, 99};
      1:       cut = '{10, 20, 30, 45, 95};
      default: cut = '{25, 42, 57, 72, 97};
    endcase
    r = $urandom_range(0, 99);
    if (r < cut[0]) return OP_PUSH;
    if (r < cut[1]) return OP_APPEND;
    if (r < cut[2]) return OP_ANCHOR;
    if (r < cut[3]) return OP_PEEK;
    if (r < cut[4]) return OP_POP;
    return 3'($urandom_range(5, 7));
  endfunction

  task automatic add_cmd(logic [2:0] op, logic [6:0] col, logic [6:0] row,
                         logic signed [7:0] value, logic signed [7:0] mark);
    stack_cmd_t c;
    c = '{op, col, row, value, mark};
    cmd_queue.push_back(c);
  endtask

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  // driver
  always @(posedge clk) begin
    stack_cmd_t    c;
    stack_result_t r;
    logic          start_next;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        c = cmd_queue.pop_front();
        r = stack_step(c);
        pending_results.push_back(r);
        if (cmd_queue.size() > QUIET_TAIL && $urandom_range(0, 3) == 0)
          idle_left = $urandom_range(1, 14);
      end
      start_next = 1'b0;
      if (idle_left > 0) begin
        idle_left--;
      end else if (cmd_queue.size() != 0) begin
        c = cmd_queue[0];
        operation  <= c.operation;
        in_col     <= c.col;
        in_row     <= c.row;
        in_value   <= c.value;
        in_mark    <= c.mark;
        start_next = 1'b1;
      end
      start <= start_next;
    end
  end

  // monitor
  always @(posedge clk) begin
    stack_result_t e;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual status %0d fill %0d",
                 $time, status, fill_count);
        mismatch_count++;
      end else begin
        e = pending_results.pop_front();
        check_field("status", e.status, status);
        check_field("out_col", e.col, out_col);
        check_field("out_row", e.row, out_row);
        check_field("out_value", e.value, out_value);
        check_field("out_mark", e.mark, out_mark);
        check_field("anchor_present", e.anchor, anchor_present);
        check_field("is_empty", e.empty, is_empty);
        check_field("fill_count", e.fill, fill_count);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int mode;
    int seg_len;
    int added;
    // empty-stack cases and an unknown code on an empty stack
    add_cmd(OP_POP, 7'd0, 7'd0, 8'sd0, 8'sd0);
    add_cmd(OP_PEEK, 7'd0, 7'd0, 8'sd0, 8'sd0);
    add_cmd(OP_ANCHOR, 7'd0, 7'd0, 8'sd0, 8'sd0);
    add_cmd(3'd5, 7'd127, 7'd127, 8'sd127, 8'sd1);
    // field extremes, anchor set twice, peek clears it
    add_cmd(OP_PUSH, 7'd127, 7'd127, 8'sd127, 8'sd1);
    add_cmd(OP_PUSH, 7'd0, 7'd0, -8'sd128, -8'sd128);
    add_cmd(OP_PEEK, 7'd0, 7'd0, 8'sd0, 8'sd0);
    add_cmd(OP_ANCHOR, 7'd0, 7'd0, 8'sd0, 8'sd0);
    add_cmd(OP_ANCHOR, 7'd0, 7'd0, 8'sd0, 8'sd0);
    add_cmd(OP_PEEK, 7'd0, 7'd0, 8'sd0, 8'sd0);
    add_cmd(OP_PEEK, 7'd0, 7'd0, 8'sd0, 8'sd0);
    // bottom appends: an anchor and marks that do not count
    add_cmd(OP_APPEND, 7'd0, 7'd127, -8'sd1, MARK_ANCHOR);
    add_cmd(OP_APPEND, 7'd127, 7'd0, 8'sd0, -8'sd128);
    add_cmd(OP_APPEND, 7'd85, 7'd42, 8'sd85, 8'sd127);
    add_cmd(3'd6, 7'd0, 7'd0, 8'sd0, 8'sd0);
    add_cmd(3'd7, 7'd0, 7'd0, 8'sd0, 8'sd0);
    add_cmd(OP_ANCHOR, 7'd0, 7'd0, 8'sd0, 8'sd0);
    repeat (6) add_cmd(OP_POP, 7'd0, 7'd0, 8'sd0, 8'sd0);
    add_cmd(OP_PEEK, 7'd0, 7'd0, 8'sd0, 8'sd0);

    added = 0;
    while (added < RANDOM_ITEMS) begin
      mode    = $urandom_range(0, 2);
      seg_len = $urandom_range(20, 90);
      repeat (seg_len) begin
        cmd_queue.push_back(make_cmd(pick_op(mode)));
        added++;
      end
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    while (cmd_queue.size() != 0 || pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/aus_pkg.sv
src/aus_ram.sv
src/aus_ctrl.sv
src/anchored_undo_stack_top.sv
tb/tb_anchored_undo_stack_top.sv
